>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the text_language_sniffer design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Constants, language codes and matcher helpers of the text language sniffer.
// ----------------------------------------------------------------------------
package tls_pkg;

  // Test line length and the counter that covers it
  localparam int WINDOW_LEN = 40;
  localparam int WCNT_W     = $clog2(WINDOW_LEN + 1);

  // Language codes of a result beat
  typedef enum logic [3:0] {
    LANG_TEXT   = 4'd0,
    LANG_SHELL  = 4'd1,
    LANG_PYTHON = 4'd2,
    LANG_PERL   = 4'd3,
    LANG_PHP    = 4'd4,
    LANG_RUBY   = 4'd5,
    LANG_JS     = 4'd6,
    LANG_XML    = 4'd7,
    LANG_HTML   = 4'd8
  } lang_t;

  // Line prefixes; the shebang is entry 0 and carries no language itself
  localparam int NUM_PREFIX = 7;
  localparam int PFX_MAX    = 14;
  localparam int PFX_SHEBANG = 0;
  localparam logic [8*PFX_MAX-1:0] PFX_TEXT [NUM_PREFIX] = '{
    "#!", "<?xml", "<?php", "<html", "<HTML", "<!DOCTYPE html", "<?"
  };
  localparam int PFX_LEN [NUM_PREFIX] = '{2, 5, 5, 5, 5, 14, 2};
  localparam lang_t PFX_LANG [NUM_PREFIX] = '{
    LANG_TEXT, LANG_XML, LANG_PHP, LANG_HTML, LANG_HTML, LANG_HTML, LANG_PHP
  };

  // Interpreter names searched in a shebang line, in priority order
  localparam int NUM_KW = 6;
  localparam int KW_MAX = 6;
  localparam int KW_W   = $clog2(KW_MAX + 1);
  localparam logic [8*KW_MAX-1:0] KW_TEXT [NUM_KW] = '{
    "sh", "python", "perl", "php", "ruby", "node"
  };
  localparam int KW_LEN [NUM_KW] = '{2, 6, 4, 3, 4, 4};
  localparam lang_t KW_LANG [NUM_KW] = '{
    LANG_SHELL, LANG_PYTHON, LANG_PERL, LANG_PHP, LANG_RUBY, LANG_JS
  };

  // Strings sit right-justified, so character p of a string of length len
  // lives in byte len-1-p.
  function automatic logic [7:0] pfx_char(input int i, input int p);
    int idx;
    idx = (p < PFX_LEN[i]) ? (PFX_LEN[i] - 1 - p) : 0;
    return PFX_TEXT[i][8*idx +: 8];
  endfunction

  // A prefix stays alive if the line is already past it or the byte agrees.
  function automatic logic pfx_keep(input int i, input logic [WCNT_W-1:0] p,
                                    input logic [7:0] c);
    logic keep;
    keep = 1'b1;
    if (int'(p) < PFX_LEN[i]) begin
      keep = (pfx_char(i, int'(p)) == c);
    end
    return keep;
  endfunction

  // Match progress after one more byte. On a miss the only partial match
  // left is the first character: no keyword repeats its head before its end.
  function automatic logic [KW_W-1:0] kw_step(input int w, input logic [KW_W-1:0] k,
                                              input logic [7:0] c);
    logic [7:0] want;
    logic [7:0] first;
    logic [KW_W-1:0] nxt;
    int idx;
    idx   = (int'(k) < KW_LEN[w]) ? (KW_LEN[w] - 1 - int'(k)) : (KW_LEN[w] - 1);
    want  = KW_TEXT[w][8*idx +: 8];
    first = KW_TEXT[w][8*(KW_LEN[w]-1) +: 8];
    if (int'(k) < KW_LEN[w] && c == want) begin
      nxt = k + KW_W'(1);
    end else if (c == first) begin
      nxt = KW_W'(1);
    end else begin
      nxt = '0;
    end
    return nxt;
  endfunction

endpackage

>>> design/text_language_sniffer.sv
// ----------------------------------------------------------------------------
// text_language_sniffer
// Guesses the language of a document from its leading bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one document byte per beat,
//   with in_last_byte set on the final byte. Only that beat yields a result.
//   Result channel (out_valid / out_stall) carries one out_language code per
//   document: 0 text, 1 shell, 2 python, 3 perl, 4 php, 5 ruby,
//   6 javascript, 7 xml, 8 html.
//   Result: registered, valid in the cycle after the last byte is accepted.
//   Throughput: one byte per cycle while in_stall is low; every byte only
//   steps small match counters and prefix flags, and the verdict is formed
//   from those in the same cycle as the last byte.
//   After the last byte all matcher state returns to its reset value, so the
//   next byte opens a new document with no gap.
//   Stall: while a result waits under out_stall, ordinary bytes are still
//   taken; only a further last byte is held off by in_stall.
//   Reset: synchronous, active low; clears the matcher and drops out_valid.
// ----------------------------------------------------------------------------
module text_language_sniffer
  import tls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_language
);

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_LINE = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // Matcher state
  logic [2:0]            seen_r,   seen_nxt;
  logic [23:0]           lead_r,   lead_nxt;
  phase_t                phase_r,  phase_nxt;
  logic [WCNT_W-1:0]     wcnt_r,   wcnt_nxt;
  logic [NUM_PREFIX-1:0] pflag_r,  pflag_nxt;
  logic [KW_W-1:0]       kprog_r  [NUM_KW];
  logic [KW_W-1:0]       kprog_nxt[NUM_KW];
  logic [NUM_KW-1:0]     kfound_r, kfound_nxt;

  // Result register
  logic  out_valid_r;
  lang_t out_language_r;
  lang_t lang;

  logic in_acc;
  logic is_ws;
  logic is_eol;
  logic is_bom;
  logic [KW_W-1:0] kstep;

  // Hold a last byte only while the previous result is still waiting
  assign in_stall = out_valid_r & out_stall & in_last_byte;
  assign in_acc   = in_valid & ~in_stall;

  assign is_eol = (in_text_byte == 8'h0A) || (in_text_byte == 8'h0D);
  assign is_ws  = is_eol || (in_text_byte == 8'h20) || (in_text_byte == 8'h09);

  // Advance the matcher by one byte
  always_comb begin
    seen_nxt   = seen_r;
    lead_nxt   = lead_r;
    phase_nxt  = phase_r;
    wcnt_nxt   = wcnt_r;
    pflag_nxt  = pflag_r;
    kfound_nxt = kfound_r;
    kstep      = '0;
    for (int w = 0; w < NUM_KW; w++) begin
      kprog_nxt[w] = kprog_r[w];
    end

    if (seen_r < 3'd3) begin
      lead_nxt[8*seen_r[1:0] +: 8] = in_text_byte;
    end
    if (seen_r < 3'd4) begin
      seen_nxt = seen_r + 3'd1;
    end

    if (phase_r == PH_SKIP && !is_ws) begin
      phase_nxt = PH_LINE;
    end

    if (phase_nxt == PH_LINE) begin
      if (is_eol) begin
        phase_nxt = PH_DONE;
      end else begin
        for (int i = 0; i < NUM_PREFIX; i++) begin
          pflag_nxt[i] = pflag_r[i] & pfx_keep(i, wcnt_r, in_text_byte);
        end
        for (int w = 0; w < NUM_KW; w++) begin
          if (!kfound_r[w]) begin
            kstep = kw_step(w, kprog_r[w], in_text_byte);
            if (int'(kstep) >= KW_LEN[w]) begin
              kfound_nxt[w] = 1'b1;
              kprog_nxt[w]  = '0;
            end else begin
              kprog_nxt[w]  = kstep;
            end
          end
        end
        wcnt_nxt = wcnt_r + WCNT_W'(1);
        if (int'(wcnt_nxt) >= WINDOW_LEN) begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  // Form the verdict from the state after this byte
  assign is_bom = (lead_nxt == 24'hBFBBEF) || (lead_nxt[15:0] == 16'hFFFE) ||
                  (lead_nxt[15:0] == 16'hFEFF);

  always_comb begin
    lang = LANG_TEXT;
    if (seen_nxt > 3'd3 && !is_bom && phase_nxt != PH_SKIP) begin
      // Later prefixes first, so the earliest hit is written last
      for (int i = NUM_PREFIX - 1; i > PFX_SHEBANG; i--) begin
        if (pflag_nxt[i] && int'(wcnt_nxt) >= PFX_LEN[i]) begin
          lang = PFX_LANG[i];
        end
      end
      if (pflag_nxt[PFX_SHEBANG] && int'(wcnt_nxt) >= PFX_LEN[PFX_SHEBANG] &&
          kfound_nxt != '0) begin
        for (int w = NUM_KW - 1; w >= 0; w--) begin
          if (kfound_nxt[w]) begin
            lang = KW_LANG[w];
          end
        end
      end
    end
  end

  // Hold matcher state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      lead_r      <= '0;
      phase_r     <= PH_SKIP;
      wcnt_r      <= '0;
      pflag_r     <= '1;
      kfound_r    <= '0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < NUM_KW; w++) begin
        kprog_r[w] <= '0;
      end
    end else begin
      // Raise valid on a last-byte beat, drop it once the result is taken
      if (in_acc && in_last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_last_byte) begin
          // Drop the document and start afresh
          seen_r      <= '0;
          lead_r      <= '0;
          phase_r     <= PH_SKIP;
          wcnt_r      <= '0;
          pflag_r     <= '1;
          kfound_r    <= '0;
          for (int w = 0; w < NUM_KW; w++) begin
            kprog_r[w] <= '0;
          end
        end else begin
          seen_r   <= seen_nxt;
          lead_r   <= lead_nxt;
          phase_r  <= phase_nxt;
          wcnt_r   <= wcnt_nxt;
          pflag_r  <= pflag_nxt;
          kfound_r <= kfound_nxt;
          for (int w = 0; w < NUM_KW; w++) begin
            kprog_r[w] <= kprog_nxt[w];
          end
        end
      end
    end
  end

  // Load the result code on a last-byte beat
  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      out_language_r <= lang;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_language = out_language_r;

`include "assert_macros.svh"

  `ASSERT_ANY(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_no_overwrite, out_valid && out_stall && in_valid && in_last_byte |-> in_stall,
              "waiting result would be overwritten")
  `ASSERT_CLK(a_last_gives_result, in_acc && in_last_byte |=> out_valid,
              "last byte gave no result")
  `ASSERT_CLK(a_window_bound, int'(wcnt_r) <= WINDOW_LEN, "test line longer than window")
  `ASSERT_CLK(a_skip_empty, phase_r == PH_SKIP |-> wcnt_r == '0 && kfound_r == '0,
              "line bytes taken while skipping whitespace")

endmodule

>>> tb/sv/text_language_sniffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_language_sniffer_tb
// Self-checking bench for the language sniffer. Documents are streamed in as
// byte beats with random gaps and result back-pressure. A behavioral sniffer
// tracks every accepted byte and queues the language it predicts for each
// document. Every result beat is checked against the oldest queued language.
// ----------------------------------------------------------------------------
module text_language_sniffer_tb;
  import tls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int FEED_TARGET = 1500;
  localparam int DOC_TARGET  = 80;
  localparam int N_PFX       = 7;
  localparam int N_KW        = 6;
  localparam int PFX_BANG    = 0;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] BOM8_A   = 8'hEF;
  localparam logic [7:0] BOM8_B   = 8'hBB;
  localparam logic [7:0] BOM8_C   = 8'hBF;
  localparam logic [7:0] BOM16_HI = 8'hFE;
  localparam logic [7:0] BOM16_LO = 8'hFF;

  typedef enum logic [1:0] {SCAN_SKIP, SCAN_LINE, SCAN_CLOSED} scan_e;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } doc_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_language;

  text_language_sniffer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_language (out_language)
  );

  // Match tables of the behavioral sniffer
  string pfx_word [N_PFX] = '{"#!", "<?xml", "<?php", "<html", "<HTML", "<!DOCTYPE html", "<?"};
  lang_t pfx_lang [N_PFX] = '{LANG_TEXT, LANG_XML, LANG_PHP, LANG_HTML, LANG_HTML,
                              LANG_HTML, LANG_PHP};
  string kw_word  [N_KW]  = '{"sh", "python", "perl", "php", "ruby", "node"};
  lang_t kw_lang  [N_KW]  = '{LANG_SHELL, LANG_PYTHON, LANG_PERL, LANG_PHP, LANG_RUBY,
                              LANG_JS};
  string char_pool = "shpytonerlbdi/ #!<?xmHTLD-\t\r\n";

  // Sniffer state of the document in flight
  logic [2:0] doc_bytes;
  logic [7:0] head_b [3];
  scan_e      scan;
  int         line_len;
  logic [6:0] pfx_alive;
  int         kw_prog [N_KW];
  logic [5:0] kw_hit;

  lang_t      lang_due [$];
  doc_beat_t  byte_feed [$];
  logic [7:0] doc [$];
  int         docs_built;
  int         feed_total;
  int         fed_count;
  int         mismatches;
  int         cycle_count;
  logic       in_taken;

  // ---------------------------------------------------------------------------
  // Behavioral sniffer
  // ---------------------------------------------------------------------------
  function automatic void sniff_clear();
    doc_bytes = '0;
    head_b    = '{8'h00, 8'h00, 8'h00};
    scan      = SCAN_SKIP;
    line_len  = 0;
    pfx_alive = '1;
    kw_hit    = '0;
    for (int w = 0; w < N_KW; w++) kw_prog[w] = 0;
  endfunction

  // Longest keyword head that ends the matched text followed by c
  function automatic int kw_advance(input int w, input int k, input logic [7:0] c);
    logic [7:0] t [8];
    int len;
    int n;
    logic ok;
    len = kw_word[w].len();
    if (k >= len) k = 0;
    for (int m = 0; m < k; m++) t[m] = kw_word[w][m];
    t[k] = c;
    n = k + 1;
    for (int j = n; j > 0; j--) begin
      if (j <= len) begin
        ok = 1'b1;
        for (int m = 0; m < j; m++) begin
          if (t[n-j+m] != kw_word[w][m]) ok = 1'b0;
        end
        if (ok) return j;
      end
    end
    return 0;
  endfunction

  function automatic logic pfx_found(input int i);
    return pfx_alive[i] && line_len >= pfx_word[i].len();
  endfunction

  function automatic lang_t sniff_verdict();
    if (doc_bytes <= 3) return LANG_TEXT;
    if ((head_b[0] == BOM8_A && head_b[1] == BOM8_B && head_b[2] == BOM8_C) ||
        (head_b[0] == BOM16_HI && head_b[1] == BOM16_LO) ||
        (head_b[0] == BOM16_LO && head_b[1] == BOM16_HI)) return LANG_TEXT;
    if (scan == SCAN_SKIP) return LANG_TEXT;
    if (pfx_found(PFX_BANG)) begin
      for (int w = 0; w < N_KW; w++) if (kw_hit[w]) return kw_lang[w];
    end
    for (int i = 1; i < N_PFX; i++) if (pfx_found(i)) return pfx_lang[i];
    return LANG_TEXT;
  endfunction

  // Advance the sniffer by one accepted byte; queue a language on the last one
  function automatic void sniff_byte(input logic [7:0] c, input logic last);
    int k;
    lang_t verdict;
    if (doc_bytes < 3) head_b[doc_bytes] = c;
    if (doc_bytes < 4) doc_bytes = doc_bytes + 3'd1;
    if (scan == SCAN_SKIP && !(c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR))
      scan = SCAN_LINE;
    if (scan == SCAN_LINE) begin
      if (c == CH_CR || c == CH_LF) begin
        scan = SCAN_CLOSED;
      end else begin
        for (int i = 0; i < N_PFX; i++) begin
          if (line_len < pfx_word[i].len() && pfx_word[i][line_len] != c) pfx_alive[i] = 1'b0;
        end
        for (int w = 0; w < N_KW; w++) begin
          if (!kw_hit[w]) begin
            k = kw_advance(w, kw_prog[w], c);
            if (k >= kw_word[w].len()) begin
              kw_hit[w] = 1'b1;
              k = 0;
            end
            kw_prog[w] = k;
          end
        end
        line_len++;
        if (line_len >= WINDOW_LEN) scan = SCAN_CLOSED;
      end
    end
    if (last) begin
      verdict  = sniff_verdict();
      lang_due = {lang_due, verdict};
      sniff_clear();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Document building
  // ---------------------------------------------------------------------------
  // Append one byte to the document under construction
  function automatic void doc_add(input logic [7:0] c);
    doc = {doc, c};
  endfunction

  function automatic void doc_put(input string s);
    for (int i = 0; i < s.len(); i++) doc_add(s[i]);
  endfunction

  // Move the built document into the feed, flagging its final byte
  function automatic void doc_ship();
    doc_beat_t b;
    for (int i = 0; i < doc.size(); i++) begin
      b.text = doc[i];
      b.last = (i == doc.size() - 1);
      byte_feed = {byte_feed, b};
    end
    doc.delete();
    docs_built++;
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return char_pool[$urandom_range(0, char_pool.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Mostly well-formed headers with random content, some broken or noisy
  task automatic make_random_doc();
    int kind;
    int w;
    int cut;
    int idx;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          doc_add(BOM8_A);
          doc_add(BOM8_B);
          doc_add(BOM8_C);
        end
        1: begin
          doc_add(BOM16_HI);
          doc_add(BOM16_LO);
        end
        default: begin
          doc_add(BOM16_LO);
          doc_add(BOM16_HI);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) doc_add(pick_space());
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        doc_put("#!");
        repeat ($urandom_range(0, 10)) doc_add(pick_char());
        repeat ($urandom_range(0, 2)) begin
          w   = $urandom_range(0, N_KW - 1);
          cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, kw_word[w].len())
                                            : kw_word[w].len();
          doc_put(kw_word[w].substr(0, cut - 1));
          repeat ($urandom_range(0, 3)) doc_add(pick_char());
        end
      end
      4, 5, 6, 7, 8: begin
        w   = $urandom_range(1, N_PFX - 1);
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, pfx_word[w].len())
                                          : pfx_word[w].len();
        doc_put(pfx_word[w].substr(0, cut - 1));
      end
      default: begin
        repeat ($urandom_range(1, 12)) doc_add(pick_char());
      end
    endcase
    // Tail, now and then long enough to run past the window
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12))
      doc_add(pick_char());
    if (doc.size() > 0 && $urandom_range(0, 4) == 0) begin
      idx = $urandom_range(0, doc.size() - 1);
      doc[idx] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, 5);
      while (doc.size() > cut) void'(doc.pop_back());
    end
    if (doc.size() == 0) doc_add(pick_char());
    doc_ship();
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next byte beat at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_beats
    logic      nv;
    logic [7:0] nb;
    logic      nl;
    doc_beat_t b;
    int        stage;
    int        send_idle;
    int        recv_idle;
    nv = in_valid;
    nb = in_text_byte;
    nl = in_last_byte;
    stage = (feed_total > 0) ? (fed_count * 3) / feed_total : 2;
    send_idle = (stage == 0) ? 36 : (stage == 1) ? 82 : 0;
    recv_idle = (stage == 0) ? 82 : (stage == 1) ? 36 : 0;
    if (rst_n && (!in_valid || in_taken)) begin
      nv = 1'b0;
      if (byte_feed.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        b  = byte_feed.pop_front();
        nv = 1'b1;
        nb = b.text;
        nl = b.last;
        fed_count++;
      end
    end
    in_valid     <= nv;
    in_text_byte <= nb;
    in_last_byte <= nl;
    out_stall    <= rst_n && ($urandom_range(0, 99) < recv_idle);
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result beats and feed accepted bytes to the sniffer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    lang_t want;
    cycle_count++;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (lang_due.size() == 0) begin
          $display("%0t: unexpected result beat, language %0d", $time, out_language);
          mismatches++;
        end else begin
          want = lang_due.pop_front();
          if (out_language !== want) begin
            $display("%0t: language mismatch, expected %0d, actual %0d",
                     $time, want, out_language);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        sniff_byte(in_text_byte, in_last_byte);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_language_sniffer test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = 8'h00;
    in_last_byte = 1'b0;
    out_stall    = 1'b0;
    in_taken     = 1'b0;
    docs_built   = 0;
    fed_count    = 0;
    feed_total   = 0;
    mismatches   = 0;
    cycle_count  = 0;
    sniff_clear();

    // Short documents and byte order marks
    doc_put("a");                   doc_ship();
    doc_put("#!s");                 doc_ship();
    doc_put("<?x");                 doc_ship();
    doc_add(BOM8_A); doc_add(BOM8_B); doc_add(BOM8_C);
    doc_put("#!sh");                doc_ship();
    doc_add(BOM16_HI); doc_add(BOM16_LO);
    doc_put("<?xml");               doc_ship();
    doc_add(BOM16_LO); doc_add(BOM16_HI);
    doc_put("<?php");               doc_ship();
    // Only whitespace
    doc_put("  \t\r\n \t");         doc_ship();
    // Shebang keywords, priority and no keyword at all
    doc_put("#!/bin/bash\n");       doc_ship();
    doc_put("#!/usr/bin/python3");  doc_ship();
    doc_put("#!perl -w");           doc_ship();
    doc_put("#!/usr/bin/phphp");    doc_ship();
    doc_put("#! rubyy");            doc_ship();
    doc_put("#!/usr/bin/env node"); doc_ship();
    doc_put("#!pythonsh");          doc_ship();
    doc_put("#!/opt/xyz\n");        doc_ship();
    // Prefixes, a line shorter than its prefix, and bytes after the line
    doc_put("\n\r <?xml v");        doc_ship();
    doc_put("<html");               doc_ship();
    doc_put("<HTML>");              doc_ship();
    doc_put("<!DOCTYPE html>");     doc_ship();
    doc_put("<!DOCTYPE htm\nl");    doc_ship();
    doc_put("<htm");                doc_ship();
    doc_put("<? x");                doc_ship();
    doc_put("#!/bin/x\npython");    doc_ship();
    // Keyword at the very end of the window and just past it
    doc_put("#!"); repeat (32) doc_add("x"); doc_put("python"); doc_ship();
    doc_put("#!"); repeat (33) doc_add("x"); doc_put("python"); doc_ship();

    while (byte_feed.size() < FEED_TARGET || docs_built < DOC_TARGET) make_random_doc();
    feed_total = byte_feed.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain the feed and every queued language, then let the pipe settle
    while (byte_feed.size() > 0 || in_valid || lang_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_language_sniffer test passed");
    end else begin
      $display("text_language_sniffer test failed");
    end
    $finish;
  end

endmodule
